// File: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by every module under hdl/.
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_W     = 5;
  localparam int OCC_W     = 5;
  localparam int DATA_W    = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // contents of one cell of the chain
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } cell_data_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } cell_cmd_t;

endpackage

// File: hdl/spq_cell.sv
// One compare-and-shift cell of the sorted chain; cell 0 holds the top entry.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  cell_data_t up_data,
  input  logic       up_greater,
  input  cell_data_t dn_data,
  output cell_data_t data,
  output logic       greater
);

  logic                     valid_r, valid_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic signed [DATA_W-1:0] prio_r, prio_nxt;

  // entry stays above a new one of strictly lower priority; a new entry of equal priority goes above it
  assign greater = valid_r && (prio_r > cmd.prio);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (cmd.push) begin
      if (!greater) begin
        if (up_greater) begin
          valid_nxt = 1'b1;
          value_nxt = cmd.value;
          prio_nxt  = cmd.prio;
        end else begin
          valid_nxt = up_data.valid;
          value_nxt = up_data.value;
          prio_nxt  = up_data.prio;
        end
      end
    end else if (cmd.pop) begin
      valid_nxt = dn_data.valid;
      value_nxt = dn_data.value;
      prio_nxt  = dn_data.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign data.valid = valid_r;
  assign data.value = value_r;
  assign data.prio  = prio_r;

endmodule

// File: hdl/spq_out_buf.sv
// Output register with skid stage for result transactions.
// Depends on spq_pkg.
module spq_out_buf
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      take;

  assign take = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r && take) begin
      main_nxt       = skid_r;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

// File: hdl/sorted_priority_queue.sv
// Sorted priority queue: a chain of DEPTH compare cells, top entry in cell 0.
// Each accepted transaction's result is registered in spq_out_buf; throughput one
// operation per cycle while in_stall is low, set by the shift of the cell chain.
// Reset (rst_n low, synchronous) empties the queue and sets capacity to 16.
// Depends on spq_pkg, spq_cell and spq_out_buf.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             accept;
  logic             buf_full;
  logic             full;
  logic             empty;
  cell_cmd_t        cmd;
  out_item_t        res;
  cell_data_t       cell_q  [DEPTH];
  logic             greater [DEPTH];
  logic [DEPTH-1:0] valid_vec;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !in_stall;

  assign full  = (CMPW'(count_r) >= CMPW'(cap_r)) || (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    cmd.push  = 1'b0;
    cmd.pop   = 1'b0;
    cmd.value = in_data.item_value;
    cmd.prio  = in_data.item_priority;
    count_nxt = count_r;
    res.out_value = '0;
    res.status    = ST_OK;
    case (in_data.op)
      OP_PUSH: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          cmd.push  = accept;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_value = cell_q[0].value;
          if (in_data.op == OP_POP) begin
            cmd.pop   = accept;
            count_nxt = count_r - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
    res.occupancy = OCC_W'(count_nxt);
  end

  assign cap_nxt = (cfg_valid && cfg_ready) ? cfg_data : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      count_r <= '0;
    end else begin
      cap_r <= cap_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cell_data_t up_d, dn_d;
    logic       up_g;
    if (k == 0) begin : g_top
      // nothing sits above the top cell, so it takes a new entry it does not outrank
      assign up_d = '0;
      assign up_g = 1'b1;
    end else begin : g_mid
      assign up_d = cell_q[k-1];
      assign up_g = greater[k-1];
    end
    if (k == DEPTH - 1) begin : g_bot
      assign dn_d = '0;
    end else begin : g_nbot
      assign dn_d = cell_q[k+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .up_data    (up_d),
      .up_greater (up_g),
      .dn_data    (dn_d),
      .data       (cell_q[k]),
      .greater    (greater[k])
    );
    assign valid_vec[k] = cell_q[k].valid;
  end

  spq_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_cells_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("cell valid bits disagree with entry count");

  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> valid_vec[0])
    else $error("top cell empty while queue holds entries");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_POP && !empty) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not remove an entry");

endmodule
